### rtl/core/fpcss_pkg.sv
`default_nettype none
package fpcss_pkg;

    // configuration register indexes
    localparam logic [1:0] CFG_SLOT_COUNT     = 2'd0;
    localparam logic [1:0] CFG_REAL_TIME_MODE = 2'd1;

    localparam int unsigned SLOT_COUNT_RESET = 1;

    // one result item
    typedef struct packed {
        logic [1:0] out_path;
        logic       camera_switched;
        logic [4:0] slot_position;
        logic       queue_advanced;
        logic [2:0] filled_buffer;
        logic [2:0] current_buffer;
        logic [3:0] reported_channel;
        logic       reported_field_even;
    } result_t;

endpackage
`default_nettype wire

### rtl/core/field_pair_camera_switch_sequencer_unit.sv
// channel  signals                                           direction
// in       in_valid, in_ready, path, channel, channel_valid,  into block
//          signal_lost, field_even, frame_mode, buffer_locked
// out      out_valid, out_ready, out_path, camera_switched,    out of block
//          slot_position, queue_advanced, filled_buffer,
//          current_buffer, reported_channel, reported_field_even
// cfg      cfg_valid, cfg_ready, cfg_index, cfg_data          into block
//
// one item per cycle sustained while out_ready is high; a result reaches the output
// through the input register, then the result register
// the pairing flags and counters are read and written back in the same cycle
// the item sits in the input register, so consecutive items see each other
// rst_n clears all pairing state and slot and queue indexes, and resets the config registers
// an output stall holds the result register; the input register still fills,
// and in_ready drops only while both registers are full and out_ready is low
`default_nettype none
module field_pair_camera_switch_sequencer_unit #(
    parameter int NUM_PATHS    = 4,
    parameter int NUM_CHANNELS = 16,
    parameter int QUEUE_DEPTH  = 8,
    parameter int MAX_SLOTS    = 32
) (
    input  wire logic       clk,
    input  wire logic       rst_n,

    input  wire logic       in_valid,
    output logic            in_ready,
    input  wire logic [1:0] path,
    input  wire logic [3:0] channel,
    input  wire logic       channel_valid,
    input  wire logic       signal_lost,
    input  wire logic       field_even,
    input  wire logic       frame_mode,
    input  wire logic       buffer_locked,

    output logic            out_valid,
    input  wire logic       out_ready,
    output logic [1:0]      out_path,
    output logic            camera_switched,
    output logic [4:0]      slot_position,
    output logic            queue_advanced,
    output logic [2:0]      filled_buffer,
    output logic [2:0]      current_buffer,
    output logic [3:0]      reported_channel,
    output logic            reported_field_even,

    input  wire logic       cfg_valid,
    output logic            cfg_ready,
    input  wire logic [1:0] cfg_index,
    input  wire logic [5:0] cfg_data
);
    import fpcss_pkg::*;

    localparam int CH_IDX_W   = (NUM_CHANNELS > 1) ? $clog2(NUM_CHANNELS) : 1;
    localparam int PATH_IDX_W = (NUM_PATHS > 1) ? $clog2(NUM_PATHS) : 1;
    localparam int QW         = $clog2(QUEUE_DEPTH);
    localparam int SLOT_W     = (MAX_SLOTS > 1) ? $clog2(MAX_SLOTS) : 1;
    localparam int LIM_W      = SLOT_W + 2;

    // config
    logic [5:0] slot_count_reg;
    logic       real_time_mode_reg;

    // input register
    logic       s1_valid_reg;
    logic [1:0] s1_path_reg;
    logic [3:0] s1_channel_reg;
    logic       s1_chvalid_reg;
    logic       s1_lost_reg;
    logic       s1_even_reg;
    logic       s1_frame_reg;
    logic       s1_locked_reg;

    // result register
    logic       out_valid_reg;
    result_t    res_reg;
    result_t    res_next;

    // pairing state per channel
    logic       odd_seen_reg     [NUM_CHANNELS];
    logic       even_seen_reg    [NUM_CHANNELS];
    logic       odd_sent_reg     [NUM_CHANNELS];
    logic       even_sent_reg    [NUM_CHANNELS];
    logic [7:0] odd_counter_reg  [NUM_CHANNELS];
    logic [7:0] even_counter_reg [NUM_CHANNELS];
    // per path
    logic [SLOT_W-1:0] slot_index_reg  [NUM_PATHS];
    logic [QW-1:0]     queue_index_reg [NUM_PATHS];

    logic [3:0] mod_tbl [16];

    logic advance;
    logic fire;

    assign advance   = !out_valid_reg || out_ready;
    assign fire      = s1_valid_reg && advance;
    assign in_ready  = !s1_valid_reg || advance;
    assign cfg_ready = 1'b1;

    for (genvar i = 0; i < 16; i++) begin : g_mod
        assign mod_tbl[i] = 4'(i % NUM_PATHS);
    end

    // single pass over the item in the input register
    logic [CH_IDX_W-1:0]   ch_idx;
    logic [PATH_IDX_W-1:0] p_idx;
    logic                  path_ok;
    logic                  chan_ok;
    logic                  pair_upd;
    logic                  os, es, osn, esn;
    logic [7:0]            oc, ec;
    logic                  os_n, es_n, osn_n, esn_n;
    logic [7:0]            oc_n, ec_n;
    logic                  sw, q;
    logic [SLOT_W-1:0]     cur_slot, slot_n;
    logic [QW-1:0]         cur_q, q_n;
    logic [LIM_W-1:0]      limit, slot_inc;
    logic [QW:0]           q_inc;

    always_comb
    begin
        ch_idx   = CH_IDX_W'(s1_channel_reg);
        p_idx    = PATH_IDX_W'(s1_path_reg);
        path_ok  = 32'(s1_path_reg) < NUM_PATHS;
        chan_ok  = s1_chvalid_reg && (32'(s1_channel_reg) < NUM_CHANNELS);
        pair_upd = path_ok && !s1_locked_reg && !s1_lost_reg && chan_ok;

        os  = odd_seen_reg[ch_idx];
        es  = even_seen_reg[ch_idx];
        osn = odd_sent_reg[ch_idx];
        esn = even_sent_reg[ch_idx];
        oc  = odd_counter_reg[ch_idx];
        ec  = even_counter_reg[ch_idx];
        os_n = os; es_n = es; osn_n = osn; esn_n = esn;
        oc_n = oc; ec_n = ec;
        sw = 1'b0;
        q  = 1'b0;

        if (pair_upd) begin
            if (!s1_frame_reg) begin
                if (!s1_even_reg) begin
                    oc_n = oc + 8'd1;
                    if (os) begin
                        if (oc_n > 8'd1) begin
                            q = 1'b1; sw = 1'b1;
                            os_n = 1'b0; oc_n = 8'd0;
                        end
                    end else begin
                        os_n = 1'b1;
                    end
                end else begin
                    os_n = 1'b0; oc_n = 8'd0;
                    q = 1'b1; sw = 1'b1;
                end
            end else if (s1_even_reg) begin
                oc_n = oc + 8'd1;
                if (!esn) begin
                    // first even of a frame completes the buffer without a switch
                    es_n = 1'b0; os_n = 1'b0; osn_n = 1'b1; esn_n = 1'b1;
                    oc_n = 8'd0;
                    q = 1'b1;
                end else begin
                    esn_n = 1'b0;
                    if (os) begin
                        if (oc_n > 8'd1) begin
                            q = 1'b1; sw = 1'b1;
                            osn_n = 1'b0; es_n = 1'b0; os_n = 1'b0; oc_n = 8'd0;
                        end
                    end else begin
                        os_n = 1'b1;
                    end
                end
            end else begin
                ec_n = ec + 8'd1;
                esn_n = 1'b0;
                if (osn || (es && ec_n > 8'd1)) begin
                    q = 1'b1; sw = 1'b1;
                    osn_n = 1'b0; es_n = 1'b0; os_n = 1'b0; ec_n = 8'd0;
                end else if (!es) begin
                    es_n = 1'b1;
                end
            end
        end else if (path_ok && !s1_locked_reg) begin
            // no sync or no camera: only the slot can move (on an even field or in frame mode)
            sw = s1_frame_reg || s1_even_reg;
        end

        cur_slot = slot_index_reg[p_idx];
        cur_q    = queue_index_reg[p_idx];
        limit    = (32'(slot_count_reg) > MAX_SLOTS) ? LIM_W'(MAX_SLOTS)
                                                     : LIM_W'(slot_count_reg);
        slot_inc = LIM_W'(cur_slot) + LIM_W'(1);
        slot_n   = (slot_inc >= limit) ? '0 : SLOT_W'(slot_inc);
        if (!sw) begin
            slot_n = cur_slot;
        end
        q_inc = (QW+1)'(cur_q) + (QW+1)'(1);
        q_n   = (32'(q_inc) >= QUEUE_DEPTH) ? '0 : QW'(q_inc);
        if (!q) begin
            q_n = cur_q;
        end

        res_next = '0;
        res_next.out_path = s1_path_reg;
        if (path_ok) begin
            res_next.camera_switched = sw;
            res_next.slot_position   = 5'(slot_n);
            res_next.queue_advanced  = q;
            res_next.current_buffer  = 3'(q_n);
            if (q) begin
                res_next.filled_buffer       = 3'(cur_q);
                res_next.reported_channel    = real_time_mode_reg
                                               ? mod_tbl[s1_channel_reg]
                                               : s1_channel_reg;
                res_next.reported_field_even = s1_even_reg;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            slot_count_reg     <= 6'(SLOT_COUNT_RESET);
            real_time_mode_reg <= 1'b0;
        end else if (cfg_valid) begin
            unique case (cfg_index)
                CFG_SLOT_COUNT:     slot_count_reg     <= cfg_data;
                CFG_REAL_TIME_MODE: real_time_mode_reg <= cfg_data[0];
                default:            ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            if (in_ready) begin
                s1_valid_reg <= in_valid;
            end
            if (advance) begin
                out_valid_reg <= s1_valid_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready) begin
            s1_path_reg    <= path;
            s1_channel_reg <= channel;
            s1_chvalid_reg <= channel_valid;
            s1_lost_reg    <= signal_lost;
            s1_even_reg    <= field_even;
            s1_frame_reg   <= frame_mode;
            s1_locked_reg  <= buffer_locked;
        end
        if (fire) begin
            res_reg <= res_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            for (int i = 0; i < NUM_CHANNELS; i++) begin
                odd_seen_reg[i]     <= 1'b0;
                even_seen_reg[i]    <= 1'b0;
                odd_sent_reg[i]     <= 1'b0;
                even_sent_reg[i]    <= 1'b0;
                odd_counter_reg[i]  <= 8'd0;
                even_counter_reg[i] <= 8'd0;
            end
            for (int j = 0; j < NUM_PATHS; j++) begin
                slot_index_reg[j]  <= '0;
                queue_index_reg[j] <= '0;
            end
        end else if (fire) begin
            if (pair_upd) begin
                odd_seen_reg[ch_idx]     <= os_n;
                even_seen_reg[ch_idx]    <= es_n;
                odd_sent_reg[ch_idx]     <= osn_n;
                even_sent_reg[ch_idx]    <= esn_n;
                odd_counter_reg[ch_idx]  <= oc_n;
                even_counter_reg[ch_idx] <= ec_n;
            end
            if (path_ok) begin
                slot_index_reg[p_idx]  <= slot_n;
                queue_index_reg[p_idx] <= q_n;
            end
        end
    end

    assign out_valid           = out_valid_reg;
    assign out_path            = res_reg.out_path;
    assign camera_switched     = res_reg.camera_switched;
    assign slot_position       = res_reg.slot_position;
    assign queue_advanced      = res_reg.queue_advanced;
    assign filled_buffer       = res_reg.filled_buffer;
    assign current_buffer      = res_reg.current_buffer;
    assign reported_channel    = res_reg.reported_channel;
    assign reported_field_even = res_reg.reported_field_even;

    // an empty result register never holds off the input
    a_ready_when_empty: assert property (@(posedge clk) disable iff (!rst_n)
        !out_valid_reg |-> in_ready)
        else $error("in_ready low with empty result register");

    // the report fields stay zero unless a buffer completed
    a_no_report_without_advance: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && !res_reg.queue_advanced) |->
        (res_reg.filled_buffer == 3'd0 && res_reg.reported_channel == 4'd0
         && !res_reg.reported_field_even))
        else $error("buffer report without queue advance");

    // a completed buffer is always followed by the next one in the ring
    a_queue_step: assert property (@(posedge clk) disable iff (!rst_n)
        (fire && q) |->
        (q_n == ((32'(cur_q) + 1 >= QUEUE_DEPTH) ? '0 : QW'(32'(cur_q) + 1))))
        else $error("queue index did not step by one");

    // a stalled result stays put
    a_hold_on_stall: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && !out_ready) |=> (out_valid_reg && $stable(res_reg)))
        else $error("result changed under stall");

endmodule
`default_nettype wire
